FILE: hw/rtl/uvsg_pkg.sv
// Shared types, constants and helper functions of the UV-sphere vertex generator.
package uvsg_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int MAX_DIVISIONS_DEF = 255;

	// One restoring step per quotient bit after the first.
	localparam int DIV_STEPS = 32;
	localparam int QUO_W     = DIV_STEPS + 1;

	localparam int XY_W = 34;
	localparam int Z_W  = 32;
	localparam int T_W  = 32;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [XY_W-1:0] ONE_XY      = 34'sd1073741824;
	localparam logic signed [T_W-1:0]  HALF_PHASE  = 32'sd536870912;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_STACKS = 2'd1,
		REG_SLICES = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] radius;
		logic [7:0]  stack_count;
		logic [7:0]  slice_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       rem;
		logic [7:0]       dvs;
		logic [QUO_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [1:0]             quad;
	} cordic_t;

	typedef struct packed {
		logic signed [T_W-1:0] cs;
		logic signed [T_W-1:0] sn;
	} trig_t;

	typedef struct packed {
		logic        quad_valid;
		logic [15:0] quad_first;
		logic [15:0] quad_second;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
	} side_t;

	// Arctangent of 2^-k as a fraction of a full turn, 2^32 to the turn.
	function automatic logic signed [Z_W-1:0] atan_phase(input int k);
		case (k)
			0: return 32'sd536870912;
			1: return 32'sd316933406;
			2: return 32'sd167458907;
			3: return 32'sd85004756;
			4: return 32'sd42667331;
			5: return 32'sd21354465;
			6: return 32'sd10680862;
			7: return 32'sd5340245;
			8: return 32'sd2670163;
			9: return 32'sd1335087;
			10: return 32'sd667544;
			11: return 32'sd333772;
			12: return 32'sd166886;
			13: return 32'sd83443;
			14: return 32'sd41721;
			15: return 32'sd20860;
			16: return 32'sd10430;
			17: return 32'sd5215;
			18: return 32'sd2607;
			19: return 32'sd1303;
			20: return 32'sd651;
			21: return 32'sd325;
			22: return 32'sd162;
			23: return 32'sd81;
			default: return 32'sd0;
		endcase
	endfunction

endpackage

FILE: hw/rtl/uvsg_div_cell.sv
// One restoring division step: doubles the remainder and emits one quotient bit.
module uvsg_div_cell import uvsg_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);

	logic [8:0] dbl;
	logic [8:0] diff;
	logic       ge;

	always_comb begin
		dbl  = {d.rem, 1'b0};
		diff = dbl - {1'b0, d.dvs};
		ge   = dbl >= {1'b0, d.dvs};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= ge ? diff[7:0] : dbl[7:0];
			q.dvs <= d.dvs;
			q.quo <= {d.quo[QUO_W-2:0], ge};
		end
	end

endmodule

FILE: hw/rtl/uvsg_cordic_cell.sv
// One CORDIC rotation step with a fixed shift, registered.
module uvsg_cordic_cell import uvsg_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic signed [Z_W-1:0]  ang;

	always_comb begin
		dx  = d.x >>> SHIFT;
		dy  = d.y >>> SHIFT;
		ang = atan_phase(SHIFT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!d.z[Z_W-1]) begin
				q.x <= d.x - dy;
				q.y <= d.y + dx;
				q.z <= d.z - ang;
			end else begin
				q.x <= d.x + dy;
				q.y <= d.y - dx;
				q.z <= d.z + ang;
			end
			q.quad <= d.quad;
		end
	end

endmodule

FILE: hw/rtl/uvsg_cfg_regs.sv
// APB-style register file holding radius, stack count and slice count.
module uvsg_cfg_regs import uvsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.radius      <= 16'd256;
			cfg.stack_count <= 8'd16;
			cfg.slice_count <= 8'd32;
		end else if (wr) begin
			case (idx)
				REG_RADIUS: cfg.radius <= pwdata[15:0];
				REG_STACKS: cfg.stack_count <= pwdata[7:0];
				REG_SLICES: cfg.slice_count <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RADIUS: prdata = {16'd0, cfg.radius};
			REG_STACKS: prdata = {24'd0, cfg.stack_count};
			REG_SLICES: prdata = {24'd0, cfg.slice_count};
			default: prdata = 32'd0;
		endcase
	end

endmodule

FILE: hw/rtl/uv_sphere_vertex_generator.sv
// Top level of the UV-sphere vertex generator: divider, CORDIC and product pipeline.
//
//   Channel   Handshake           Payload
//   in        in_valid/in_ready   stack_index, slice_index
//   out       out_valid/out_ready pos_x/y/z, norm_x/y/z, tex_u/v, quad_valid/first/second
//   config    APB (psel..pready)  sphere_radius @0, stack_count @4, slice_count @8
//
// One request enters per cycle while the pipeline is not halted. Its result passes the input
// register, the chain of 32 restoring divider cells that turn the indices into angle
// phases, the phase preparation register, the chain of CORDIC cells (sixteen stages by
// default), then the quadrant, product and output registers. Reset clears the valid
// bits of every stage and loads the register defaults. When the output register holds
// a result that is not taken, the whole pipeline halts and in_ready falls; otherwise a
// request is taken every cycle.
//
// The grid indices are clamped to the counts, then each angle phase is found as
// floor(index * 2^32 / count) by a row of division cells carrying remainder and
// quotient from one cell to the next. The texture coordinates come from the same
// quotients with a rounding shift. Two parallel CORDIC chains give the sine and
// cosine of the polar and azimuth angles, and the last stages form the products,
// the rounded normal and the radius-scaled position.
module uv_sphere_vertex_generator import uvsg_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              stack_index,
	input  logic [7:0]              slice_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [16:0]      pos_x,
	output logic signed [16:0]      pos_y,
	output logic signed [16:0]      pos_z,
	output logic signed [15:0]      norm_x,
	output logic signed [15:0]      norm_y,
	output logic signed [15:0]      norm_z,
	output logic [15:0]             tex_u,
	output logic [15:0]             tex_v,
	output logic                    quad_valid,
	output logic [15:0]             quad_first,
	output logic [15:0]             quad_second
);

	// Stage positions along the pipeline, the input register being position zero.
	localparam int PREP_POS = DIV_STEPS + 1;
	localparam int CORD_END = PREP_POS + CORDIC_STAGES;
	localparam int OUT_POS  = CORD_END + 3;
	localparam int NSTAGE   = OUT_POS + 1;
	localparam logic [7:0] MAX_CNT = 8'(MAX_DIVISIONS);

	cfg_t cfg;

	uvsg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The whole pipeline moves together unless the output register is full and held.
	logic              en;
	logic [NSTAGE-1:0] vld_q;
	side_t             side_q [NSTAGE];

	assign en        = ~vld_q[OUT_POS] | out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[OUT_POS];

	// Input stage: effective counts, clamping, quad indices and division set-up.
	logic [7:0]  stk_eff;
	logic [7:0]  slc_eff;
	logic [7:0]  ic;
	logic [7:0]  jc;
	logic        in_quad;
	logic [16:0] first_full;
	logic [15:0] first_idx;
	logic [15:0] second_idx;

	always_comb begin
		if (cfg.stack_count == 8'd0)
			stk_eff = 8'd1;
		else if (cfg.stack_count > MAX_CNT)
			stk_eff = MAX_CNT;
		else
			stk_eff = cfg.stack_count;
		if (cfg.slice_count == 8'd0)
			slc_eff = 8'd1;
		else if (cfg.slice_count > MAX_CNT)
			slc_eff = MAX_CNT;
		else
			slc_eff = cfg.slice_count;
		ic         = (stack_index > stk_eff) ? stk_eff : stack_index;
		jc         = (slice_index > slc_eff) ? slc_eff : slice_index;
		in_quad    = (stack_index < stk_eff) && (slice_index < slc_eff);
		first_full = 17'(stack_index) * 17'({1'b0, slc_eff} + 9'd1) + 17'(slice_index);
		first_idx  = in_quad ? first_full[15:0] : 16'd0;
		second_idx = in_quad ? (first_full[15:0] + 16'(slc_eff) + 16'd1) : 16'd0;
	end

	div_t phi_dv [DIV_STEPS+1];
	div_t th_dv  [DIV_STEPS+1];
	div_t phi_div_s1;
	div_t th_div_s1;

	// The clamped index never exceeds its count, so the leading quotient bit is
	// simply whether they are equal.
	always_ff @(posedge clk) begin
		if (en) begin
			phi_div_s1.dvs <= stk_eff;
			phi_div_s1.rem <= (ic == stk_eff) ? 8'd0 : ic;
			phi_div_s1.quo <= QUO_W'(ic == stk_eff);
			th_div_s1.dvs  <= slc_eff;
			th_div_s1.rem  <= (jc == slc_eff) ? 8'd0 : jc;
			th_div_s1.quo  <= QUO_W'(jc == slc_eff);
		end
	end

	assign phi_dv[0] = phi_div_s1;
	assign th_dv[0]  = th_div_s1;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		uvsg_div_cell u_phi (.clk(clk), .en(en), .d(phi_dv[k]), .q(phi_dv[k+1]));
		uvsg_div_cell u_th  (.clk(clk), .en(en), .d(th_dv[k]),  .q(th_dv[k+1]));
	end

	// Phase preparation. The polar phase is half the division result, the azimuth
	// phase its low 32 bits. Both texture coordinates round the quotient at bit 17.
	logic [T_W-1:0]   phi_phase;
	logic [T_W-1:0]   th_phase;
	logic [T_W-1:0]   phi_rot;
	logic [T_W-1:0]   th_rot;
	logic [QUO_W:0]   tex_u_sum;
	logic [QUO_W:0]   tex_v_sum;
	cordic_t          phi_cord_s2;
	cordic_t          th_cord_s2;

	always_comb begin
		phi_phase = phi_dv[DIV_STEPS].quo[QUO_W-1:1];
		th_phase  = th_dv[DIV_STEPS].quo[T_W-1:0];
		phi_rot   = phi_phase + 32'h2000_0000;
		th_rot    = th_phase + 32'h2000_0000;
		tex_v_sum = {1'b0, phi_dv[DIV_STEPS].quo} + (QUO_W+1)'(32'h0001_0000);
		tex_u_sum = {1'b0, th_dv[DIV_STEPS].quo} + (QUO_W+1)'(32'h0001_0000);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_cord_s2.x    <= CORDIC_GAIN;
			phi_cord_s2.y    <= '0;
			phi_cord_s2.z    <= $signed({2'b00, phi_rot[29:0]}) - HALF_PHASE;
			phi_cord_s2.quad <= phi_rot[31:30];
			th_cord_s2.x     <= CORDIC_GAIN;
			th_cord_s2.y     <= '0;
			th_cord_s2.z     <= $signed({2'b00, th_rot[29:0]}) - HALF_PHASE;
			th_cord_s2.quad  <= th_rot[31:30];
		end
	end

	cordic_t phi_cc [CORDIC_STAGES+1];
	cordic_t th_cc  [CORDIC_STAGES+1];

	assign phi_cc[0] = phi_cord_s2;
	assign th_cc[0]  = th_cord_s2;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		uvsg_cordic_cell #(.SHIFT(k)) u_phi (
			.clk (clk), .en (en), .d (phi_cc[k]), .q (phi_cc[k+1])
		);
		uvsg_cordic_cell #(.SHIFT(k)) u_th (
			.clk (clk), .en (en), .d (th_cc[k]), .q (th_cc[k+1])
		);
	end

	// Clamp the rotated vector to the unit and rotate it back into its quadrant.
	function automatic trig_t quad_map(input cordic_t c);
		logic signed [XY_W-1:0] xc;
		logic signed [XY_W-1:0] yc;
		logic signed [T_W-1:0]  xs;
		logic signed [T_W-1:0]  ys;
		trig_t                  r;
		xc = (c.x > ONE_XY) ? ONE_XY : ((c.x < -ONE_XY) ? -ONE_XY : c.x);
		yc = (c.y > ONE_XY) ? ONE_XY : ((c.y < -ONE_XY) ? -ONE_XY : c.y);
		xs = T_W'(xc);
		ys = T_W'(yc);
		case (c.quad)
			2'd0: begin r.cs = xs;  r.sn = ys;  end
			2'd1: begin r.cs = -ys; r.sn = xs;  end
			2'd2: begin r.cs = -xs; r.sn = -ys; end
			default: begin r.cs = ys; r.sn = -xs; end
		endcase
		return r;
	endfunction

	trig_t phi_trig_s3;
	trig_t th_trig_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			phi_trig_s3 <= quad_map(phi_cc[CORDIC_STAGES]);
			th_trig_s3  <= quad_map(th_cc[CORDIC_STAGES]);
		end
	end

	// Products of the polar sine with the azimuth terms, rounded to Q2.30.
	logic signed [63:0]    prod_x;
	logic signed [63:0]    prod_z;
	logic signed [63:0]    sum_x;
	logic signed [63:0]    sum_z;
	logic signed [T_W-1:0] tx_s4;
	logic signed [T_W-1:0] tz_s4;
	logic signed [T_W-1:0] cp_s4;

	always_comb begin
		prod_x = phi_trig_s3.sn * th_trig_s3.cs;
		prod_z = phi_trig_s3.sn * th_trig_s3.sn;
		sum_x  = prod_x + 64'sd536870912;
		sum_z  = prod_z + 64'sd536870912;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4 <= T_W'(sum_x >>> 30);
			tz_s4 <= T_W'(sum_z >>> 30);
			cp_s4 <= phi_trig_s3.cs;
		end
	end

	function automatic logic signed [16:0] to_pos(input logic signed [T_W-1:0] t,
			input logic [15:0] rad);
		logic signed [48:0] p;
		logic signed [49:0] s;
		logic signed [19:0] r;
		p = $signed({1'b0, rad}) * t;
		s = 50'(p) + 50'sd536870912;
		r = 20'(s >>> 30);
		if (r > 20'sd65535)
			r = 20'sd65535;
		else if (r < -20'sd65535)
			r = -20'sd65535;
		return 17'(r);
	endfunction

	function automatic logic signed [15:0] to_norm(input logic signed [T_W-1:0] t);
		logic signed [32:0] s;
		logic signed [16:0] r;
		s = 33'(t) + 33'sd32768;
		r = 17'(s >>> 16);
		if (r > 17'sd16384)
			r = 17'sd16384;
		else if (r < -17'sd16384)
			r = -17'sd16384;
		return 16'(r);
	endfunction

	logic signed [16:0] pos_x_s5;
	logic signed [16:0] pos_y_s5;
	logic signed [16:0] pos_z_s5;
	logic signed [15:0] norm_x_s5;
	logic signed [15:0] norm_y_s5;
	logic signed [15:0] norm_z_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x_s5  <= to_pos(tx_s4, cfg.radius);
			pos_y_s5  <= to_pos(cp_s4, cfg.radius);
			pos_z_s5  <= to_pos(tz_s4, cfg.radius);
			norm_x_s5 <= to_norm(tx_s4);
			norm_y_s5 <= to_norm(cp_s4);
			norm_z_s5 <= to_norm(tz_s4);
		end
	end

	// Valid bits and the side fields travel alongside; the texture coordinates
	// join the side fields as they pass the phase preparation stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0].quad_valid  <= in_quad;
			side_q[0].quad_first  <= first_idx;
			side_q[0].quad_second <= second_idx;
			side_q[0].tex_u       <= 16'd0;
			side_q[0].tex_v       <= 16'd0;
			for (int p = 1; p < NSTAGE; p++) begin
				if (p == PREP_POS) begin
					side_q[p].quad_valid  <= side_q[p-1].quad_valid;
					side_q[p].quad_first  <= side_q[p-1].quad_first;
					side_q[p].quad_second <= side_q[p-1].quad_second;
					side_q[p].tex_u       <= tex_u_sum[QUO_W-1:17];
					side_q[p].tex_v       <= tex_v_sum[QUO_W-1:17];
				end else begin
					side_q[p] <= side_q[p-1];
				end
			end
		end
	end

	assign pos_x       = pos_x_s5;
	assign pos_y       = pos_y_s5;
	assign pos_z       = pos_z_s5;
	assign norm_x      = norm_x_s5;
	assign norm_y      = norm_y_s5;
	assign norm_z      = norm_z_s5;
	assign tex_u       = side_q[OUT_POS].tex_u;
	assign tex_v       = side_q[OUT_POS].tex_v;
	assign quad_valid  = side_q[OUT_POS].quad_valid;
	assign quad_first  = side_q[OUT_POS].quad_first;
	assign quad_second = side_q[OUT_POS].quad_second;

endmodule

FILE: tb/sv/uv_sphere_vertex_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the UV-sphere vertex generator: predicted vertices against the DUT.
module uv_sphere_vertex_generator_test;
	import uvsg_pkg::*;

	localparam int LATENCY = 53;
	localparam longint CYCLE_LIMIT = 1500000;

	// A predicted vertex, with every field at the width of its port.
	typedef struct {
		logic signed [16:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [15:0] u, v;
		logic qv;
		logic [15:0] qf, qs;
	} vertex_t;

	typedef struct {
		logic [7:0] stk;
		logic [7:0] slc;
	} grid_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] stack_index = '0, slice_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic [15:0] tex_u, tex_v;
	logic quad_valid;
	logic [15:0] quad_first, quad_second;

	uv_sphere_vertex_generator uut (.*);

	// The predictor's own copy of the registers.
	logic [15:0] radius_q88 = 16'd256;
	logic [7:0] stacks_reg = 8'd16;
	logic [7:0] slices_reg = 8'd32;

	grid_point_t pending_points[$];
	vertex_t expected_vertices[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	longint cycle_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint shr_floor(longint val, int k);
		return val >>> k;
	endfunction

	function automatic longint sat(longint val, longint lim);
		return val < -lim ? -lim : (val > lim ? lim : val);
	endfunction

	// Cosine and sine (Q2.30) of a 32-bit phase by the fixed-gain CORDIC rotation.
	task automatic cordic_trig(input logic [31:0] phase, output longint c, output longint s);
		logic [31:0] r;
		longint x, y, z, dx, dy;
		r = phase + 32'h2000_0000;
		z = longint'(r[29:0]) - 64'sd536870912;
		x = 652032874;
		y = 0;
		for (int k = 0; k < 16; k++) begin
			dx = shr_floor(y, k);
			dy = shr_floor(x, k);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_phase(k));
			end else begin
				x += dx; y -= dy; z += longint'(atan_phase(k));
			end
		end
		x = sat(x, 64'sd1073741824);
		y = sat(y, 64'sd1073741824);
		case (r[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic longint to_pos_q88(longint t);
		return sat(shr_floor(longint'(radius_q88) * t + (64'sd1 <<< 29), 30), 65535);
	endfunction

	function automatic longint to_norm_q214(longint t);
		return sat(shr_floor(t + (64'sd1 <<< 15), 16), 16384);
	endfunction

	// Works out the vertex that one grid point should produce under the current settings.
	task automatic predict_vertex(input grid_point_t gp, output vertex_t vx);
		longint stacks, slices, ic, jc, cp, sp, ct, st, tx, tz, first;
		logic [31:0] phi_phase, theta_phase;
		stacks = (stacks_reg == 0) ? 1 : stacks_reg;
		slices = (slices_reg == 0) ? 1 : slices_reg;
		ic = (gp.stk > stacks) ? stacks : gp.stk;
		jc = (gp.slc > slices) ? slices : gp.slc;
		phi_phase = 32'((ic <<< 31) / stacks);
		theta_phase = 32'((jc <<< 32) / slices);
		cordic_trig(phi_phase, cp, sp);
		cordic_trig(theta_phase, ct, st);
		tx = shr_floor(sp * ct + (64'sd1 <<< 29), 30);
		tz = shr_floor(sp * st + (64'sd1 <<< 29), 30);
		vx.px = 17'(to_pos_q88(tx));
		vx.py = 17'(to_pos_q88(cp));
		vx.pz = 17'(to_pos_q88(tz));
		vx.nx = 16'(to_norm_q214(tx));
		vx.ny = 16'(to_norm_q214(cp));
		vx.nz = 16'(to_norm_q214(tz));
		vx.u = 16'((jc * 65536 + slices) / (2 * slices));
		vx.v = 16'((ic * 65536 + stacks) / (2 * stacks));
		vx.qv = (gp.stk < stacks) && (gp.slc < slices);
		first = vx.qv ? longint'(gp.stk) * (slices + 1) + gp.slc : 0;
		vx.qf = 16'(first);
		vx.qs = vx.qv ? 16'(first + slices + 1) : 16'd0;
	endtask

	// Driver: the request is held until it is taken; the prediction is made on acceptance,
	// which is safe because registers only change while the block is idle.
	always @(posedge clk) begin
		vertex_t vx;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_vertex('{stack_index, slice_index}, vx);
				expected_vertices.insert(expected_vertices.size(), vx);
			end
			if ((!in_valid || in_ready) && pending_points.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				stack_index <= pending_points[0].stk;
				slice_index <= pending_points[0].slc;
				void'(pending_points.pop_front());
			end else if (in_ready) begin
				in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: each result taken is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		vertex_t ev;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t: result with nothing expected", $time);
					error_count <= error_count + 1;
				end else begin
					ev = expected_vertices.pop_front();
					if (ev.px !== pos_x || ev.py !== pos_y || ev.pz !== pos_z
							|| ev.nx !== norm_x || ev.ny !== norm_y || ev.nz !== norm_z
							|| ev.u !== tex_u || ev.v !== tex_v || ev.qv !== quad_valid
							|| ev.qf !== quad_first || ev.qs !== quad_second) begin
						$display("%0t: expected pos %0d %0d %0d norm %0d %0d %0d uv %0d %0d quad %0b %0d %0d",
							$time, ev.px, ev.py, ev.pz, ev.nx, ev.ny, ev.nz, ev.u, ev.v,
							ev.qv, ev.qf, ev.qs);
						$display("%0t: actual   pos %0d %0d %0d norm %0d %0d %0d uv %0d %0d quad %0b %0d %0d",
							$time, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
							quad_valid, quad_first, quad_second);
						error_count <= error_count + 1;
					end
				end
			end
		end
	end

	// The run stops at a generous cycle count whatever else happens.
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("uv_sphere_vertex_generator regression: fail");
			$finish;
		end
	end

	// One APB write: a setup cycle, then the access cycle at whose edge the register loads.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_RADIUS: radius_q88 = data[15:0];
			REG_STACKS: stacks_reg = data[7:0];
			default: slices_reg = data[7:0];
		endcase
	endtask

	// Waits for every queued request to be taken and every result to come back.
	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// Appends one grid point to the tail of the pending queue.
	task automatic add_point(input logic [7:0] stk, input logic [7:0] slc);
		grid_point_t gp;
		gp.stk = stk;
		gp.slc = slc;
		pending_points.insert(pending_points.size(), gp);
	endtask

	// Mostly in-range grid points, with a share beyond the counts and across the whole byte.
	task automatic queue_random(input int n);
		int stacks, slices;
		stacks = (stacks_reg == 0) ? 1 : stacks_reg;
		slices = (slices_reg == 0) ? 1 : slices_reg;
		repeat (n) begin
			if ($urandom_range(9) < 7)
				add_point(8'($urandom_range(stacks)), 8'($urandom_range(slices)));
			else
				add_point(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points at the reset settings: poles, equator, seams, overrun and extremes.
		add_point(8'd0, 8'd0);
		add_point(8'd16, 8'd32);
		add_point(8'd8, 8'd0);
		add_point(8'd8, 8'd8);
		add_point(8'd8, 8'd16);
		add_point(8'd8, 8'd24);
		add_point(8'd15, 8'd31);
		add_point(8'd16, 8'd0);
		add_point(8'd0, 8'd32);
		add_point(8'd255, 8'd255);
		add_point(8'd170, 8'd85);
		add_point(8'd85, 8'd170);
		add_point(8'd4, 8'd5);
		drain();

		// Zero radius still gives unit normals; counts of zero behave as one.
		apb_write(REG_RADIUS, 32'hFFFF_0000);
		apb_write(REG_STACKS, 32'h0000_0000);
		apb_write(REG_SLICES, 32'hFFFF_FF00);
		add_point(8'd0, 8'd0);
		add_point(8'd1, 8'd1);
		add_point(8'd0, 8'd1);
		add_point(8'd200, 8'd0);
		drain();

		// Largest radius and counts, so positions saturate and indices reach the top.
		apb_write(REG_RADIUS, 32'h0000_FFFF);
		apb_write(REG_STACKS, 32'd255);
		apb_write(REG_SLICES, 32'd255);
		add_point(8'd254, 8'd254);
		add_point(8'd255, 8'd255);
		add_point(8'd128, 8'd64);
		add_point(8'd64, 8'd191);
		drain();

		// Random phases, each with its own settings, cycling through four idling and stalling patterns.
		for (int ph = 0; ph < 8; ph++) begin
			apb_write(REG_RADIUS, $urandom);
			apb_write(REG_STACKS, (ph == 1) ? 32'd1 : ((ph & 1) ? $urandom : $urandom_range(40)));
			apb_write(REG_SLICES, (ph == 2) ? 32'd1 : ((ph & 1) ? $urandom : $urandom_range(40)));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 78; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 78; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			queue_random(70);
			// The sender pauses once until every result is back, then resumes.
			while (pending_points.size() > 0 || in_valid || expected_vertices.size() > 0)
				@(posedge clk);
			queue_random(65);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		if (error_count == 0)
			$display("uv_sphere_vertex_generator regression: pass");
		else
			$display("uv_sphere_vertex_generator regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/uvsg_pkg.sv
hw/rtl/uvsg_div_cell.sv
hw/rtl/uvsg_cordic_cell.sv
hw/rtl/uvsg_cfg_regs.sv
hw/rtl/uv_sphere_vertex_generator.sv
tb/sv/uv_sphere_vertex_generator_test.sv
